[sv/tfr_pkg.sv]
// Shared types and constants for the transport frame reassembler.
package tfr_pkg;

    // Fixed field widths
    localparam int OFFSET_W = 12;
    localparam int FRAME_BYTES = 8;

    // Frame-type codes (high nibble of the PCI byte)
    localparam logic [3:0] TYPE_SINGLE      = 4'd0;
    localparam logic [3:0] TYPE_FIRST       = 4'd1;
    localparam logic [3:0] TYPE_CONSECUTIVE = 4'd2;

    // Flow-control frame layout
    localparam logic [7:0] FC_CTS_BYTE   = 8'h30;
    localparam logic [2:0] FC_IDX_CTS    = 3'd0;
    localparam logic [2:0] FC_IDX_BS     = 3'd1;
    localparam logic [2:0] FC_IDX_STMIN  = 3'd2;
    localparam logic [2:0] FC_IDX_LAST   = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_FILLER    = 2'd0;
    localparam logic [1:0] CFG_BLOCK     = 2'd1;
    localparam logic [1:0] CFG_SEP_TIME  = 2'd2;

    localparam logic [7:0] FILLER_RESET  = 8'hAA;

    // One received CAN frame
    typedef struct packed {
        logic [3:0] frame_length;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
        logic       is_physical;
    } t_frame;

    // One emitted result beat
    typedef struct packed {
        logic                kind;
        logic [OFFSET_W-1:0] byte_offset;
        logic [7:0]          data_byte;
        logic                message_complete;
        logic                physical_addressing;
        logic                last_of_run;
    } t_result;

    // Work item passed from the classifier to the emitter
    typedef struct packed {
        logic                fc;      // send flow-control frame first
        logic [2:0]          cnt;     // payload bytes to send
        logic [OFFSET_W-1:0] base;    // message offset of first payload byte
        logic [7:0][7:0]     data;    // payload bytes, entry 0 first
        logic                done;    // last payload byte completes message
        logic                phys;    // addressing latch to report
    } t_cmd;

    // Flow-control frame settings
    typedef struct packed {
        logic [7:0] filler;
        logic [7:0] block_size;
        logic [7:0] sep_time;
    } t_fc_cfg;

endpackage

[sv/tfr_front.sv]
// Frame classifier: accepts frames, keeps message state, builds emit commands.
module tfr_front
    import tfr_pkg::*;
#(
    parameter int MESSAGE_BYTES = 4096
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_frame i_frame,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    localparam int LEN_W = $clog2(MESSAGE_BYTES);
    localparam logic [OFFSET_W-1:0] MAX_LEN = OFFSET_W'(MESSAGE_BYTES - 1);

    logic [LEN_W-1:0] r_exp, n_exp;
    logic [LEN_W-1:0] r_rec, n_rec;
    logic             r_latch, n_latch;

    logic             w_accept;
    logic [3:0]       w_flen;
    logic [3:0]       w_type;
    logic [2:0]       w_avail1;
    logic [2:0]       w_avail2;
    logic [2:0]       w_sf_len;
    logic [OFFSET_W-1:0] w_total12;
    logic [LEN_W-1:0] w_total;
    logic [2:0]       w_ff_cnt;
    logic [LEN_W-1:0] w_remain;
    logic             w_completes;
    logic [2:0]       w_take;

    assign w_accept = i_valid && !i_q_full;
    assign o_stall  = i_q_full;

    // Clamp frame length and derive data-byte counts
    always_comb begin
        w_flen   = (i_frame.frame_length > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES)
                                                           : i_frame.frame_length;
        w_type   = i_frame.byte_0[7:4];
        w_avail1 = (w_flen > 4'd1) ? 3'(w_flen - 4'd1) : 3'd0;
        w_avail2 = (w_flen > 4'd2) ? 3'(w_flen - 4'd2) : 3'd0;

        // Single frame length, clamped to the bytes present
        w_sf_len = (i_frame.byte_0[3:0] > {1'b0, w_avail1}) ? w_avail1
                                                           : i_frame.byte_0[2:0];

        // First frame total, clamped to the message buffer
        w_total12 = {i_frame.byte_0[3:0], i_frame.byte_1};
        w_total   = (w_total12 > MAX_LEN) ? LEN_W'(MAX_LEN) : w_total12[LEN_W-1:0];
        w_ff_cnt  = (LEN_W'(w_avail2) > w_total) ? w_total[2:0] : w_avail2;

        // Consecutive frame share of the remaining message
        w_remain    = r_exp - r_rec;
        w_completes = (w_remain <= LEN_W'(w_avail1));
        w_take      = w_completes ? w_remain[2:0] : w_avail1;
    end

    // Classify the frame and build its command
    always_comb begin
        n_exp   = r_exp;
        n_rec   = r_rec;
        n_latch = r_latch;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.phys = r_latch;
        case (w_type)
            TYPE_SINGLE: begin
                n_latch    = i_frame.is_physical;
                n_exp      = LEN_W'(w_sf_len);
                n_rec      = LEN_W'(w_sf_len);
                o_push     = w_accept && (w_sf_len != 3'd0);
                o_cmd.cnt  = w_sf_len;
                o_cmd.done = 1'b1;
                o_cmd.phys = i_frame.is_physical;
                o_cmd.data = {8'h00, i_frame.byte_7, i_frame.byte_6, i_frame.byte_5,
                              i_frame.byte_4, i_frame.byte_3, i_frame.byte_2,
                              i_frame.byte_1};
            end
            TYPE_FIRST: begin
                n_exp      = w_total;
                n_rec      = LEN_W'(w_ff_cnt);
                o_push     = w_accept;
                o_cmd.fc   = 1'b1;
                o_cmd.cnt  = w_ff_cnt;
                o_cmd.done = (LEN_W'(w_ff_cnt) == w_total);
                o_cmd.data = {8'h00, 8'h00, i_frame.byte_7, i_frame.byte_6,
                              i_frame.byte_5, i_frame.byte_4, i_frame.byte_3,
                              i_frame.byte_2};
            end
            TYPE_CONSECUTIVE: begin
                if (r_rec < r_exp) begin
                    n_rec      = r_rec + LEN_W'(w_take);
                    o_push     = w_accept && (w_take != 3'd0);
                    o_cmd.cnt  = w_take;
                    o_cmd.base = OFFSET_W'(r_rec);
                    o_cmd.done = w_completes;
                    o_cmd.data = {8'h00, i_frame.byte_7, i_frame.byte_6,
                                  i_frame.byte_5, i_frame.byte_4, i_frame.byte_3,
                                  i_frame.byte_2, i_frame.byte_1};
                end
            end
            default: begin
            end
        endcase
    end

    // Commit message state on each accepted frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp   <= '0;
            r_rec   <= '0;
            r_latch <= 1'b0;
        end else if (w_accept) begin
            r_exp   <= n_exp;
            r_rec   <= n_rec;
            r_latch <= n_latch;
        end
    end

endmodule

[sv/tfr_queue.sv]
// Two-entry command queue between the classifier and the emitter.
module tfr_queue
    import tfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count missed a push");
`endif

endmodule

[sv/tfr_back.sv]
// Result emitter: walks each command into an output register, one beat per unstalled cycle.
module tfr_back
    import tfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_fc_cfg i_cfg,
    input  logic    i_q_avail,
    input  t_cmd    i_q_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_cmd    r_cmd;
    logic    r_busy;
    logic    r_in_fc;
    logic [2:0] r_fi;
    logic [2:0] r_pi;
    logic    r_out_valid;
    t_result r_out;

    logic    w_load;
    logic    w_pay_last;
    t_result w_res;

    assign w_load   = !r_out_valid || !i_stall;
    assign o_pop    = !r_busy && i_q_avail;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Form the current beat
    always_comb begin
        w_pay_last = (r_pi == r_cmd.cnt - 3'd1);
        w_res = '0;
        w_res.physical_addressing = r_cmd.phys;
        if (r_in_fc) begin
            w_res.kind        = 1'b1;
            w_res.byte_offset = OFFSET_W'(r_fi);
            w_res.last_of_run = (r_fi == FC_IDX_LAST) && (r_cmd.cnt == 3'd0);
            case (r_fi)
                FC_IDX_CTS:   w_res.data_byte = FC_CTS_BYTE;
                FC_IDX_BS:    w_res.data_byte = i_cfg.block_size;
                FC_IDX_STMIN: w_res.data_byte = i_cfg.sep_time;
                default:      w_res.data_byte = i_cfg.filler;
            endcase
        end else begin
            w_res.kind             = 1'b0;
            w_res.byte_offset      = r_cmd.base + OFFSET_W'(r_pi);
            w_res.data_byte        = r_cmd.data[r_pi];
            w_res.message_complete = r_cmd.done && w_pay_last;
            w_res.last_of_run      = w_pay_last;
        end
    end

    // Load commands and step through their beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_in_fc <= 1'b0;
            r_fi    <= 3'd0;
            r_pi    <= 3'd0;
        end else if (o_pop) begin
            r_busy  <= 1'b1;
            r_in_fc <= i_q_cmd.fc;
            r_fi    <= 3'd0;
            r_pi    <= 3'd0;
        end else if (r_busy && w_load) begin
            if (r_in_fc) begin
                r_fi <= r_fi + 3'd1;
                if (r_fi == FC_IDX_LAST) begin
                    r_in_fc <= 1'b0;
                    if (r_cmd.cnt == 3'd0) begin
                        r_busy <= 1'b0;
                    end
                end
            end else begin
                r_pi <= r_pi + 3'd1;
                if (w_pay_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Hold the command payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Output register: refill when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && r_busy) begin
            r_out <= w_res;
        end
    end

`ifndef SYNTHESIS
    a_complete_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.message_complete |-> r_out.last_of_run && !r_out.kind)
        else $error("completion flag on a beat that is not the final payload");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_busy)
        else $error("command popped but emitter not started");
    a_fc_before_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_in_fc |-> r_pi == 3'd0)
        else $error("payload beats started before flow-control frame ended");
`endif

endmodule

[sv/transport_frame_reassembler_core.sv]
// Top level of the transport frame reassembler: config registers and block wiring.
//
//  channel   direction  handshake            payload
//  frame     in         i_valid / o_stall    i_frame  (t_frame)
//  result    out        o_valid / i_stall    o_result (t_result)
//  config    in         i_cfg_wr_en          i_cfg_index, i_cfg_wr_data
//
// A frame is classified in the cycle it is accepted and queued as a command.
// The emitter loads a command, then emits one result per cycle while the output
// is not stalled: up to 8 flow-control beats plus 6 payload for a first frame.
// The emitter's one-beat-per-cycle walk sets the rate; the two-entry queue
// lets up to two more commands wait meanwhile. Reset is synchronous and clears
// message state; no clearing pass is needed. A stalled result holds in the output
// register; the emitter stalls behind it, the classifier once the queue is full.
module transport_frame_reassembler_core
    import tfr_pkg::*;
#(
    parameter int MESSAGE_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_frame     i_frame,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wr_data
);

    t_fc_cfg r_cfg;
    logic    w_push;
    logic    w_pop;
    logic    w_q_full;
    logic    w_q_avail;
    t_cmd    w_push_cmd;
    t_cmd    w_pop_cmd;

    // Write flow-control settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filler     <= FILLER_RESET;
            r_cfg.block_size <= 8'h00;
            r_cfg.sep_time   <= 8'h00;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FILLER:   r_cfg.filler     <= i_cfg_wr_data;
                CFG_BLOCK:    r_cfg.block_size <= i_cfg_wr_data;
                CFG_SEP_TIME: r_cfg.sep_time   <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    tfr_front #(
        .MESSAGE_BYTES(MESSAGE_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_frame  (i_frame),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    tfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_avail (w_q_avail),
        .o_cmd   (w_pop_cmd)
    );

    tfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_avail (w_q_avail),
        .i_q_cmd   (w_pop_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

endmodule

[bench/tb_top.sv]
// Self-checking bench for the transport frame reassembler: predictor, scoreboard, stimulus.
module tb_top;
    import tfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_BYTES     = 4096;
    localparam int SETTLE_CYCLES = 40;
    // Slowest run is about 400 frames of up to 14 beats each, with 13% gaps and stalls;
    // the limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 300000;

    // PCI types the block drops
    localparam logic [3:0] TYPE_FLOW_CONTROL = 4'd3;
    localparam logic [3:0] TYPE_RESERVED_TOP = 4'hF;

    // Predicts the beats of every accepted frame and checks the output stream
    class reassembly_scoreboard;
        logic [7:0] filler;
        logic [7:0] block_size;
        logic [7:0] sep_time;
        int         msg_len;
        int         rx_len;
        logic       phys_latch;
        t_result    pending_beats [$];
        int         errors;

        function new();
            filler     = FILLER_RESET;
            block_size = 8'd0;
            sep_time   = 8'd0;
            msg_len    = 0;
            rx_len     = 0;
            phys_latch = 1'b0;
            errors     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] value);
            case (idx)
                CFG_FILLER:   filler = value;
                CFG_BLOCK:    block_size = value;
                CFG_SEP_TIME: sep_time = value;
                default: ;
            endcase
        endfunction

        function bit message_open();
            return rx_len < msg_len;
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction

        function t_result make_beat(logic kind, int offset, logic [7:0] value, bit done);
            t_result beat;
            beat.kind                = kind;
            beat.byte_offset         = offset[OFFSET_W-1:0];
            beat.data_byte           = value;
            beat.message_complete    = done;
            beat.physical_addressing = phys_latch;
            beat.last_of_run         = 1'b0;
            return beat;
        endfunction

        // Work out the beats of one accepted frame and queue them
        function void note_frame(t_frame f);
            logic [7:0] fb [8];
            logic [7:0] fc_value;
            t_result    run [$];
            t_result    beat;
            int         flen;
            int         avail;
            int         len;
            int         cnt;
            int         remain;
            int         take;
            bit         completes;

            fb[0] = f.byte_0; fb[1] = f.byte_1; fb[2] = f.byte_2; fb[3] = f.byte_3;
            fb[4] = f.byte_4; fb[5] = f.byte_5; fb[6] = f.byte_6; fb[7] = f.byte_7;
            flen  = int'(f.frame_length);
            if (flen > FRAME_BYTES) flen = FRAME_BYTES;
            avail = (flen > 1) ? flen - 1 : 0;

            case (fb[0][7:4])
                TYPE_SINGLE: begin
                    len = int'(fb[0][3:0]);
                    if (len > avail) len = avail;
                    phys_latch = f.is_physical;
                    msg_len    = len;
                    rx_len     = len;
                    for (int i = 0; i < len; i++)
                        run.push_back(make_beat(1'b0, i, fb[1 + i], i + 1 == len));
                end
                TYPE_FIRST: begin
                    msg_len = int'({fb[0][3:0], fb[1]});
                    if (msg_len > MSG_BYTES - 1) msg_len = MSG_BYTES - 1;
                    cnt = (flen > 2) ? flen - 2 : 0;
                    if (cnt > msg_len) cnt = msg_len;
                    rx_len = cnt;
                    // flow-control frame goes out ahead of the payload
                    for (int i = 0; i < 8; i++) begin
                        if (i == FC_IDX_CTS)        fc_value = FC_CTS_BYTE;
                        else if (i == FC_IDX_BS)    fc_value = block_size;
                        else if (i == FC_IDX_STMIN) fc_value = sep_time;
                        else                        fc_value = filler;
                        run.push_back(make_beat(1'b1, i, fc_value, 1'b0));
                    end
                    for (int i = 0; i < cnt; i++)
                        run.push_back(make_beat(1'b0, i, fb[2 + i],
                                                i + 1 == cnt && cnt == msg_len));
                end
                TYPE_CONSECUTIVE: begin
                    // append only while a message is open
                    if (rx_len < msg_len) begin
                        remain    = msg_len - rx_len;
                        take      = (remain > avail) ? avail : remain;
                        completes = remain <= avail;
                        for (int i = 0; i < take; i++)
                            run.push_back(make_beat(1'b0, rx_len + i, fb[1 + i],
                                                    completes && i + 1 == take));
                        rx_len = (rx_len + take) & 'hFFF;
                    end
                end
                default: ;
            endcase

            if (run.size() > 0) begin
                beat = run.pop_back();
                beat.last_of_run = 1'b1;
                run.push_back(beat);
            end
            foreach (run[i]) pending_beats.push_back(run[i]);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one output beat with the oldest prediction
        function void check_beat(t_result got);
            t_result want;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual kind %0d %s",
                         $time, got.kind,
                         $sformatf("offset 0x%0h data 0x%0h", got.byte_offset,
                                   got.data_byte));
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            compare_field("kind", int'(want.kind), int'(got.kind));
            compare_field("byte_offset", int'(want.byte_offset), int'(got.byte_offset));
            compare_field("data_byte", int'(want.data_byte), int'(got.data_byte));
            compare_field("message_complete", int'(want.message_complete),
                          int'(got.message_complete));
            compare_field("physical_addressing", int'(want.physical_addressing),
                          int'(got.physical_addressing));
            compare_field("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    t_frame     i_frame       = '0;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    t_result    o_result;
    logic       i_cfg_wr_en   = 1'b0;
    logic [1:0] i_cfg_index   = CFG_FILLER;
    logic [7:0] i_cfg_wr_data = 8'd0;

    bit                   calm = 1'b0;
    int                   cycles = 0;
    reassembly_scoreboard sb = new();

    transport_frame_reassembler_core #(
        .MESSAGE_BYTES(MSG_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_frame      (i_frame),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (o_result),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random outside the calm stretch
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_beat(o_result);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, sb.outstanding());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_frame frame_with(int flen, logic [7:0] pci, logic [7:0] second);
        t_frame f;
        f.frame_length = flen[3:0];
        f.byte_0       = pci;
        f.byte_1       = second;
        f.byte_2       = 8'($urandom_range(0, 255));
        f.byte_3       = 8'($urandom_range(0, 255));
        f.byte_4       = 8'($urandom_range(0, 255));
        f.byte_5       = 8'($urandom_range(0, 255));
        f.byte_6       = 8'($urandom_range(0, 255));
        f.byte_7       = 8'($urandom_range(0, 255));
        f.is_physical  = 1'($urandom_range(0, 1));
        return f;
    endfunction

    // Offer one frame, idling at random first; returns at the falling edge after the beat
    task automatic send_frame(t_frame f);
        while (!calm && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_frame <= f;
        do @(posedge i_clk); while (o_stall);
        sb.note_frame(f);
        @(negedge i_clk);
    endtask

    // Hold the frame side off until every predicted beat has come out
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic apply_settings(logic [7:0] filler, logic [7:0] bs, logic [7:0] st);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= CFG_FILLER;
        i_cfg_wr_data <= filler;
        sb.set_register(CFG_FILLER, filler);
        @(negedge i_clk);
        i_cfg_index   <= CFG_BLOCK;
        i_cfg_wr_data <= bs;
        sb.set_register(CFG_BLOCK, bs);
        @(negedge i_clk);
        i_cfg_index   <= CFG_SEP_TIME;
        i_cfg_wr_data <= st;
        sb.set_register(CFG_SEP_TIME, st);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed messages with random content, plus strays and noise
    task automatic run_random(int quota);
        int         sent;
        int         pick;
        int         len;
        int         flen;
        int         total;
        logic [3:0] seq;
        logic [3:0] junk_type;

        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 39) == 0) wait_drain();
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                len  = $urandom_range(0, 15);
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                    : ((len > 7) ? 8 : len + 1);
                send_frame(frame_with(flen, {TYPE_SINGLE, len[3:0]},
                                      8'($urandom_range(0, 255))));
                sent++;
            end else if (pick < 85) begin
                total = ($urandom_range(0, 14) == 0) ? $urandom_range(61, 400)
                                                      : $urandom_range(0, 60);
                flen  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 8;
                send_frame(frame_with(flen, {TYPE_FIRST, total[11:8]}, total[7:0]));
                sent++;
                seq = 4'd1;
                // follow with consecutive frames, now and then breaking off early
                while (sb.message_open() && $urandom_range(0, 49) != 0) begin
                    flen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 8;
                    send_frame(frame_with(flen, {TYPE_CONSECUTIVE, seq},
                                          8'($urandom_range(0, 255))));
                    sent++;
                    seq++;
                end
            end else if (pick < 93) begin
                send_frame(frame_with($urandom_range(0, 15),
                                      {TYPE_CONSECUTIVE, 4'($urandom_range(0, 15))},
                                      8'($urandom_range(0, 255))));
                sent++;
            end else begin
                junk_type = 4'($urandom_range(TYPE_FLOW_CONTROL, TYPE_RESERVED_TOP));
                send_frame(frame_with($urandom_range(0, 15),
                                      {junk_type, 4'($urandom_range(0, 15))},
                                      8'($urandom_range(0, 255))));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset register values
        send_frame(frame_with(1, {TYPE_SINGLE, 4'd0}, 8'h11));         // zero-length single
        send_frame('{4'd8, {TYPE_SINGLE, 4'd7}, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 1'b1});
        send_frame('{4'd8, {TYPE_SINGLE, 4'd15}, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 1'b0});                         // length clamped
        send_frame(frame_with(15, {TYPE_SINGLE, 4'd5}, 8'hA5));        // frame length above 8
        send_frame(frame_with(0, {TYPE_SINGLE, 4'd3}, 8'h5A));         // no data bytes
        send_frame(frame_with(8, {TYPE_FIRST, 4'd0}, 8'd20));
        send_frame(frame_with(8, {TYPE_CONSECUTIVE, 4'd1}, 8'h01));
        send_frame(frame_with(12, {TYPE_CONSECUTIVE, 4'd2}, 8'h02));   // completes
        send_frame(frame_with(8, {TYPE_CONSECUTIVE, 4'd3}, 8'h03));    // nothing pending
        send_frame(frame_with(8, {TYPE_FIRST, 4'd0}, 8'd3));           // done inside first frame
        send_frame(frame_with(8, {TYPE_FIRST, 4'd0}, 8'd0));           // zero total length
        send_frame(frame_with(8, {TYPE_CONSECUTIVE, 4'd1}, 8'h04));
        send_frame(frame_with(1, {TYPE_FIRST, 4'hF}, 8'hFF));          // longest message, no data
        send_frame(frame_with(0, {TYPE_CONSECUTIVE, 4'd1}, 8'h05));
        send_frame(frame_with(1, {TYPE_CONSECUTIVE, 4'd2}, 8'h06));
        send_frame(frame_with(5, {TYPE_CONSECUTIVE, 4'd3}, 8'h07));
        send_frame(frame_with(2, {TYPE_FIRST, 4'd0}, 8'd10));          // restarts open message
        send_frame(frame_with(8, {TYPE_CONSECUTIVE, 4'd1}, 8'h08));
        send_frame(frame_with(3, {TYPE_SINGLE, 4'd2}, 8'h09));         // single aborts message
        send_frame(frame_with(8, {TYPE_CONSECUTIVE, 4'd2}, 8'h0A));
        send_frame(frame_with(8, {TYPE_FLOW_CONTROL, 4'd0}, 8'h0B));
        send_frame(frame_with(8, {TYPE_RESERVED_TOP, 4'd5}, 8'h0C));
        send_frame(frame_with(8, {TYPE_FIRST, 4'd0}, 8'd9));
        send_frame(frame_with(8, {TYPE_CONSECUTIVE, 4'hF}, 8'h0D));    // short tail completes

        // Random phases over several register settings
        apply_settings(8'h00, 8'h00, 8'h00);
        run_random(80);
        apply_settings(8'hFF, 8'hFF, 8'hFF);
        calm = 1'b1;
        run_random(80);
        calm = 1'b0;
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        run_random(80);
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        run_random(80);

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[transport_frame_reassembler_core.f]
sv/tfr_pkg.sv
sv/tfr_front.sv
sv/tfr_queue.sv
sv/tfr_back.sv
sv/transport_frame_reassembler_core.sv
bench/tb_top.sv
